@@ sv/two_class_priority_queue_core_assert.svh @@
// Assertion macros for the two-class priority queue core
`ifndef TWO_CLASS_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define TWO_CLASS_PRIORITY_QUEUE_CORE_ASSERT_SVH

// clocked check, disabled while in reset
`define TCPQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// clocked check that also holds during reset
`define TCPQ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ sv/tcpq_pkg.sv @@
// Package with shared types and constants of the two-class priority queue core
package tcpq_pkg;

	localparam logic [7:0] THRESHOLD_RESET = 8'd60;

	// register index, taken from paddr[2]
	localparam logic REG_THRESHOLD = 1'b0;

	typedef struct packed {
		logic [2:0]  pad;
		logic [4:0]  normal_count;
		logic [4:0]  priority_count;
		logic        dropped;
		logic        from_priority;
		logic [7:0]  served_class;
		logic [15:0] served_id;
		logic        served_valid;
	} out_beat_t;

endpackage

@@ sv/two_class_priority_queue_core.sv @@
// Top level of the two-class strict priority queue core
//
// Input stream s_*: one beat per operation. s_tuser is the action (0 enqueue,
// 1 serve); s_tdata carries item_id and class_value. Enqueues whose class
// value is at or above the threshold register go to the priority ring, others
// to the normal ring. A serve pops the priority head first, else the normal
// head. Output stream m_*: exactly one result beat per input beat, in order.
// An enqueue result is valid the cycle after it is accepted; a serve first
// reads the ring memory into a read register (state ST_READ), then its result
// is registered. One enqueue per cycle while m_tready does not stall a held
// result; a serve holds s_tready low in ST_READ, as the ring memories read synchronously.
// A single output register holds the result; a new beat is taken while it
// drains, and s_tready drops while a held result is stalled by m_tready.
// Reset empties both rings and sets the threshold to 60; ring contents are
// not cleared, only written entries are ever read.
// APB: register 0 (threshold, 8 bits) at byte address 0.
module two_class_priority_queue_core #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // item_id[15:0], class_value[23:16]
	input  logic        s_tuser,  // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // served_valid[0], served_id[16:1], served_class[24:17],
	                              // from_priority[25], dropped[26], priority_count[31:27],
	                              // normal_count[36:32], zero[39:37]
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int FW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [FW-1:0] FILL_FULL = FW'(QUEUE_DEPTH);
	localparam logic [AW-1:0] IDX_LAST  = AW'(QUEUE_DEPTH - 1);
	localparam logic [AW:0]   DEPTH_W   = (AW + 1)'(QUEUE_DEPTH);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_READ = 1'b1;

	logic [23:0] p_mem [QUEUE_DEPTH];
	logic [23:0] n_mem [QUEUE_DEPTH];

	logic          state_q;
	logic [7:0]    thr_q;
	logic [AW-1:0] p_head_q, n_head_q;
	logic [FW-1:0] p_fill_q, n_fill_q;
	logic [23:0]   p_rd_s1, n_rd_s1;
	logic          sel_p_s1, hit_s1;
	tcpq_pkg::out_beat_t out_q;
	logic          out_vld_q;

	logic acc, enq, srv, to_prio, p_full, n_full, p_wr, n_wr, take_p, take_n;
	logic [15:0] in_id;
	logic [7:0]  in_cls;
	logic [AW:0] p_sum, n_sum;
	logic [AW-1:0] p_tail, n_tail, p_head_nx, n_head_nx;
	logic [FW-1:0] p_fill_d, n_fill_d;
	logic [31:0] p_cnt_ext, n_cnt_ext, p_cur_ext, n_cur_ext;
	logic cfg_wr;

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == tcpq_pkg::REG_THRESHOLD);
	assign prdata = (paddr[2] == tcpq_pkg::REG_THRESHOLD) ? {24'b0, thr_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= tcpq_pkg::THRESHOLD_RESET;
		end else if (cfg_wr) begin
			thr_q <= pwdata[7:0];
		end
	end

	// input decode
	assign s_tready = (state_q == ST_IDLE) && (!out_vld_q || m_tready);
	assign acc      = s_tvalid && s_tready;
	assign enq      = acc && !s_tuser;
	assign srv      = acc && s_tuser;
	assign in_id    = s_tdata[15:0];
	assign in_cls   = s_tdata[23:16];
	assign to_prio  = in_cls >= thr_q;
	assign p_full   = p_fill_q == FILL_FULL;
	assign n_full   = n_fill_q == FILL_FULL;
	assign p_wr     = enq && to_prio && !p_full;
	assign n_wr     = enq && !to_prio && !n_full;
	assign take_p   = srv && (p_fill_q != '0);
	assign take_n   = srv && (p_fill_q == '0) && (n_fill_q != '0);

	// tail = (head + fill) mod depth; fill is below depth whenever it is used
	assign p_sum  = {1'b0, p_head_q} + {1'b0, p_fill_q[AW-1:0]};
	assign n_sum  = {1'b0, n_head_q} + {1'b0, n_fill_q[AW-1:0]};
	assign p_tail = (p_sum >= DEPTH_W) ? AW'(p_sum - DEPTH_W) : p_sum[AW-1:0];
	assign n_tail = (n_sum >= DEPTH_W) ? AW'(n_sum - DEPTH_W) : n_sum[AW-1:0];

	assign p_head_nx = (p_head_q == IDX_LAST) ? '0 : p_head_q + 1'b1;
	assign n_head_nx = (n_head_q == IDX_LAST) ? '0 : n_head_q + 1'b1;

	always_comb begin
		p_fill_d = p_fill_q;
		n_fill_d = n_fill_q;
		if (p_wr) p_fill_d = p_fill_q + 1'b1;
		if (n_wr) n_fill_d = n_fill_q + 1'b1;
		if (take_p) p_fill_d = p_fill_q - 1'b1;
		if (take_n) n_fill_d = n_fill_q - 1'b1;
	end

	assign p_cnt_ext = 32'(p_fill_d);
	assign n_cnt_ext = 32'(n_fill_d);
	assign p_cur_ext = 32'(p_fill_q);
	assign n_cur_ext = 32'(n_fill_q);

	// ring memories
	always_ff @(posedge clk) begin
		if (p_wr) p_mem[p_tail] <= {in_id, in_cls};
		if (srv) p_rd_s1 <= p_mem[p_head_q];
	end

	always_ff @(posedge clk) begin
		if (n_wr) n_mem[n_tail] <= {in_id, in_cls};
		if (srv) n_rd_s1 <= n_mem[n_head_q];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			p_head_q <= '0;
			n_head_q <= '0;
			p_fill_q <= '0;
			n_fill_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			p_fill_q <= p_fill_d;
			n_fill_q <= n_fill_d;
			if (take_p) p_head_q <= p_head_nx;
			if (take_n) n_head_q <= n_head_nx;
			case (state_q)
				ST_IDLE: if (srv) state_q <= ST_READ;
				ST_READ: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (enq || (state_q == ST_READ)) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (srv) begin
			sel_p_s1 <= take_p;
			hit_s1   <= take_p || take_n;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (enq) begin
			out_q.pad            <= '0;
			out_q.normal_count   <= n_cnt_ext[4:0];
			out_q.priority_count <= p_cnt_ext[4:0];
			out_q.dropped        <= !(p_wr || n_wr);
			out_q.from_priority  <= to_prio;
			out_q.served_class   <= '0;
			out_q.served_id      <= '0;
			out_q.served_valid   <= 1'b0;
		end else if (state_q == ST_READ) begin
			out_q.pad            <= '0;
			out_q.normal_count   <= n_cur_ext[4:0];
			out_q.priority_count <= p_cur_ext[4:0];
			out_q.dropped        <= 1'b0;
			out_q.from_priority  <= sel_p_s1;
			out_q.served_valid   <= hit_s1;
			if (!hit_s1) begin
				out_q.served_id    <= '0;
				out_q.served_class <= '0;
			end else if (sel_p_s1) begin
				out_q.served_id    <= p_rd_s1[23:8];
				out_q.served_class <= p_rd_s1[7:0];
			end else begin
				out_q.served_id    <= n_rd_s1[23:8];
				out_q.served_class <= n_rd_s1[7:0];
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

endmodule

@@ sv/tcpq_checker.sv @@
// Port-level checker for the two-class priority queue core, with its bind
`include "two_class_priority_queue_core_assert.svh"

module tcpq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        pready
);

	`TCPQ_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result beat dropped under stall")
	`TCPQ_ASSERT(a_srv_gap, s_tvalid && s_tready && s_tuser |=> !s_tready, "beat taken during serve read")
	`TCPQ_ASSERT(a_served_nodrop, m_tvalid |-> !(m_tdata[0] && m_tdata[26]), "served and dropped together")
	`TCPQ_ASSERT(a_idle_zero, m_tvalid && !m_tdata[0] |-> m_tdata[24:1] == 24'd0, "id or class set without serve")
	`TCPQ_ASSERT_ALWAYS(a_pready, pready, "pready low")

endmodule

bind two_class_priority_queue_core tcpq_checker u_tcpq_checker (.*);

@@ tb/two_class_priority_queue_core_tb.sv @@
// Testbench for two_class_priority_queue_core: directed table, then random stream checked against a predictor
`timescale 1ns / 100ps

module two_class_priority_queue_core_tb;

	localparam int RING_DEPTH = 16;
	localparam int RING_NORMAL = 0;
	localparam int RING_PRIO = 1;
	localparam logic ACT_ENQUEUE = 1'b0;
	localparam logic ACT_SERVE = 1'b1;
	localparam logic [2:0] ADDR_THRESHOLD = {tcpq_pkg::REG_THRESHOLD, 2'b00};
	localparam logic [2:0] ADDR_UNUSED = {!tcpq_pkg::REG_THRESHOLD, 2'b00};
	localparam tcpq_pkg::out_beat_t NO_BEAT = '0;

	typedef struct {
		logic act;
		logic [15:0] id;
		logic [7:0] cls;
		int reps;
		bit is_typed;
		tcpq_pkg::out_beat_t beat;
	} stim_row_t;

	typedef struct {
		bit is_typed;
		tcpq_pkg::out_beat_t beat;
	} typed_result_t;

	logic clk;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [23:0] s_tdata = '0;   // item_id[15:0], class_value[23:16]
	logic s_tuser = 1'b0;        // action
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [39:0] m_tdata;        // served_valid, served_id, served_class, from_priority,
	                             // dropped, priority_count, normal_count, zero pad

	// predictor state
	logic [7:0] cur_threshold = tcpq_pkg::THRESHOLD_RESET;
	logic [15:0] ring_id [2][RING_DEPTH];
	logic [7:0] ring_cls [2][RING_DEPTH];
	int ring_head [2] = '{0, 0};
	int ring_fill [2] = '{0, 0};

	tcpq_pkg::out_beat_t due_results [$];
	typed_result_t typed_results [$];

	bit steady = 1'b0;
	int errors = 0;
	int n_enq = 0, n_serve = 0, n_drop = 0, n_empty = 0, n_checked = 0, n_writes = 0;

	two_class_priority_queue_core #(
		.QUEUE_DEPTH(RING_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic tcpq_pkg::out_beat_t beat_of(bit v, logic [15:0] id, logic [7:0] cls,
			bit fp, bit dr, int pc, int nc);
		tcpq_pkg::out_beat_t b;
		b = '0;
		b.served_valid = v;
		b.served_id = id;
		b.served_class = cls;
		b.from_priority = fp;
		b.dropped = dr;
		b.priority_count = pc[4:0];
		b.normal_count = nc[4:0];
		return b;
	endfunction

	// one enqueue or serve against the two rings
	function automatic tcpq_pkg::out_beat_t queue_step(logic act, logic [15:0] id,
			logic [7:0] cls);
		tcpq_pkg::out_beat_t r;
		int q;
		int slot;
		r = '0;
		q = -1;
		if (act == ACT_ENQUEUE) begin
			q = (cls >= cur_threshold) ? RING_PRIO : RING_NORMAL;
			r.from_priority = (q == RING_PRIO);
			if (ring_fill[q] == RING_DEPTH) begin
				r.dropped = 1'b1;
			end else begin
				slot = (ring_head[q] + ring_fill[q]) % RING_DEPTH;
				ring_id[q][slot] = id;
				ring_cls[q][slot] = cls;
				ring_fill[q]++;
			end
		end else begin
			if (ring_fill[RING_PRIO] != 0) begin
				q = RING_PRIO;
				r.from_priority = 1'b1;
			end else if (ring_fill[RING_NORMAL] != 0) begin
				q = RING_NORMAL;
			end
			if (q >= 0) begin
				r.served_valid = 1'b1;
				r.served_id = ring_id[q][ring_head[q]];
				r.served_class = ring_cls[q][ring_head[q]];
				ring_head[q] = (ring_head[q] + 1) % RING_DEPTH;
				ring_fill[q]--;
			end
		end
		r.priority_count = ring_fill[RING_PRIO][4:0];
		r.normal_count = ring_fill[RING_NORMAL][4:0];
		return r;
	endfunction

	task automatic check_field(string what, int unsigned want, int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
		end
	endtask

	task automatic send_op(logic act, logic [15:0] id, logic [7:0] cls, bit is_typed,
			tcpq_pkg::out_beat_t beat);
		typed_result_t tr;
		if (!steady && $urandom_range(99) < 30) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		tr.is_typed = is_typed;
		tr.beat = beat;
		typed_results.push_back(tr);
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {cls, id};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic apb_xfer(logic wr, logic [2:0] addr, logic [31:0] wdat,
			output logic [31:0] rdat);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdat;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdat = prdata;
	endtask

	task automatic wait_drained();
		int guard;
		guard = 0;
		while ((due_results.size() != 0 || typed_results.size() != 0) && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		if (due_results.size() != 0 || typed_results.size() != 0) begin
			errors++;
			$display("%0t ns: results outstanding, expected %0d more beats, actual none",
				$time, due_results.size() + typed_results.size());
		end
	endtask

	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= 23);
	end

	// result check first, then prediction of the beat accepted at this edge
	always @(posedge clk) begin
		tcpq_pkg::out_beat_t got;
		tcpq_pkg::out_beat_t want;
		typed_result_t tr;
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				n_writes++;
				if (paddr == ADDR_THRESHOLD)
					cur_threshold = pwdata[7:0];
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (due_results.size() == 0) begin
					errors++;
					$display("%0t ns: result beat with nothing due, expected none, actual %h",
						$time, m_tdata);
				end else begin
					want = due_results.pop_front();
					n_checked++;
					check_field("served_valid", 32'(want.served_valid), 32'(got.served_valid));
					check_field("served_id", 32'(want.served_id), 32'(got.served_id));
					check_field("served_class", 32'(want.served_class), 32'(got.served_class));
					check_field("from_priority", 32'(want.from_priority),
						32'(got.from_priority));
					check_field("dropped", 32'(want.dropped), 32'(got.dropped));
					check_field("priority_count", 32'(want.priority_count),
						32'(got.priority_count));
					check_field("normal_count", 32'(want.normal_count), 32'(got.normal_count));
					check_field("pad", 32'(want.pad), 32'(got.pad));
				end
			end
			if (s_tvalid && s_tready) begin
				want = queue_step(s_tuser, s_tdata[15:0], s_tdata[23:16]);
				tr = typed_results.pop_front();
				if (tr.is_typed)
					want = tr.beat;
				due_results.push_back(want);
				if (s_tuser == ACT_ENQUEUE)
					n_enq++;
				else
					n_serve++;
				if (want.dropped)
					n_drop++;
				if (s_tuser == ACT_SERVE && !want.served_valid)
					n_empty++;
			end
		end
	end

	initial begin
		stim_row_t dir_rows [$];
		logic [7:0] thr_list [7];
		logic [31:0] rd;
		logic [31:0] wdata;
		logic act;
		logic [15:0] id;
		logic [7:0] cls;
		int p, n, r, burst_left, enq_pct;

		// threshold 60 after reset
		dir_rows.push_back('{ACT_SERVE, 16'hFFFF, 8'hFF, 1, 1'b1, beat_of(0, 0, 0, 0, 0, 0, 0)});
		dir_rows.push_back('{ACT_ENQUEUE, 16'hFFFF, 8'hFF, 1, 1'b1, beat_of(0, 0, 0, 1, 0, 1, 0)});
		dir_rows.push_back('{ACT_ENQUEUE, 16'h0000, 8'h00, 1, 1'b1, beat_of(0, 0, 0, 0, 0, 1, 1)});
		dir_rows.push_back('{ACT_ENQUEUE, 16'h1234, 8'd60, 1, 1'b1, beat_of(0, 0, 0, 1, 0, 2, 1)});
		dir_rows.push_back('{ACT_ENQUEUE, 16'hABCD, 8'd59, 1, 1'b1, beat_of(0, 0, 0, 0, 0, 2, 2)});
		dir_rows.push_back('{ACT_SERVE, 16'h0000, 8'h00, 1, 1'b1,
			beat_of(1, 16'hFFFF, 8'hFF, 1, 0, 1, 2)});
		dir_rows.push_back('{ACT_SERVE, 16'hFFFF, 8'hFF, 1, 1'b1,
			beat_of(1, 16'h1234, 8'd60, 1, 0, 0, 2)});
		dir_rows.push_back('{ACT_SERVE, 16'h5A5A, 8'hA5, 1, 1'b1,
			beat_of(1, 16'h0000, 8'h00, 0, 0, 0, 1)});
		dir_rows.push_back('{ACT_SERVE, 16'hA5A5, 8'h5A, 1, 1'b1,
			beat_of(1, 16'hABCD, 8'd59, 0, 0, 0, 0)});
		dir_rows.push_back('{ACT_SERVE, 16'hFFFF, 8'hFF, 1, 1'b1, beat_of(0, 0, 0, 0, 0, 0, 0)});
		// fill both rings, then overflow each
		dir_rows.push_back('{ACT_ENQUEUE, 16'h8000, 8'hC8, RING_DEPTH, 1'b0, NO_BEAT});
		dir_rows.push_back('{ACT_ENQUEUE, 16'h5555, 8'hFF, 1, 1'b1,
			beat_of(0, 0, 0, 1, 1, RING_DEPTH, 0)});
		dir_rows.push_back('{ACT_ENQUEUE, 16'h7F00, 8'h01, RING_DEPTH, 1'b0, NO_BEAT});
		dir_rows.push_back('{ACT_ENQUEUE, 16'hAAAA, 8'd59, 1, 1'b1,
			beat_of(0, 0, 0, 0, 1, RING_DEPTH, RING_DEPTH)});
		dir_rows.push_back('{ACT_SERVE, 16'h1234, 8'h56, 5, 1'b0, NO_BEAT});

		thr_list[0] = 8'd0;
		thr_list[1] = 8'd255;
		thr_list[2] = 8'd1;
		thr_list[3] = 8'($urandom);
		thr_list[4] = 8'd254;
		thr_list[5] = 8'($urandom);
		thr_list[6] = tcpq_pkg::THRESHOLD_RESET;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			for (r = 0; r < dir_rows[i].reps; r++)
				send_op(dir_rows[i].act, 16'(dir_rows[i].id + r), dir_rows[i].cls,
					dir_rows[i].is_typed, dir_rows[i].beat);
		s_tvalid <= 1'b0;

		for (p = 0; p < 7; p++) begin
			// sender holds off until every result is back
			wait_drained();
			repeat (4) @(posedge clk);
			if (p == 5)
				apb_xfer(1'b1, ADDR_UNUSED, $urandom, rd);
			wdata = $urandom;
			wdata[7:0] = thr_list[p];
			apb_xfer(1'b1, ADDR_THRESHOLD, wdata, rd);
			apb_xfer(1'b0, ADDR_THRESHOLD, 32'h0, rd);
			psel <= 1'b0;
			penable <= 1'b0;
			check_field("threshold readback", 32'(cur_threshold), 32'(rd[7:0]));
			steady = (p == 3);
			burst_left = 0;
			enq_pct = 50;
			for (n = 0; n < 130; n++) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(40, 8);
					case ($urandom_range(2))
						0: enq_pct = 20;
						1: enq_pct = 50;
						default: enq_pct = 80;
					endcase
				end
				burst_left--;
				act = ($urandom_range(99) < enq_pct) ? ACT_ENQUEUE : ACT_SERVE;
				id = 16'($urandom);
				if ($urandom_range(3) == 0)
					cls = 8'(cur_threshold + $urandom_range(2) - 1);
				else
					cls = 8'($urandom);
				send_op(act, id, cls, 1'b0, NO_BEAT);
			end
			s_tvalid <= 1'b0;
		end
		steady = 1'b0;

		wait_drained();
		repeat (8) @(posedge clk);

		$display("Ran %0d operations (%0d enqueues, %0d serves) across %0d register writes.",
			n_enq + n_serve, n_enq, n_serve, n_writes);
		$display("Checked %0d result beats; %0d full-ring drops, %0d serves with both rings empty.",
			n_checked, n_drop, n_empty);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
